// ----- sv/wpc_pkg.sv -----
// ----------------------------------------------------------------------------
// wpc_pkg
// Shared types and constants for the waveform peak coincidence unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wpc_pkg;

   // channel count and field widths
   localparam int CHANNELS   = 4;
   localparam int SAMPLE_W   = 12;
   localparam int IDX_W      = 12;
   localparam int LEN_W      = 13;
   localparam int SUM_W      = 17;
   localparam int DT_W       = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // record shape
   localparam int PED_COUNT  = 19;
   localparam int MAX_RECORD = 4096;
   localparam int MIN_RECORD = PED_COUNT + 1;

   // register reset values
   localparam logic [SAMPLE_W-1:0] THR_RESET [CHANNELS] = '{
      SAMPLE_W'(25), SAMPLE_W'(25), SAMPLE_W'(50), SAMPLE_W'(50)};
   localparam logic [SAMPLE_W-1:0] POLARITY_RESET = SAMPLE_W'(2000);
   localparam logic [SAMPLE_W-1:0] WIDE_RESET     = SAMPLE_W'(5);
   localparam logic [SAMPLE_W-1:0] NARROW_RESET   = SAMPLE_W'(1);
   localparam logic [LEN_W-1:0]    LENGTH_RESET   = LEN_W'(256);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD_CH1 = 3'd0,
      CSR_THRESHOLD_CH2 = 3'd1,
      CSR_THRESHOLD_CH3 = 3'd2,
      CSR_THRESHOLD_CH4 = 3'd3,
      CSR_POLARITY      = 3'd4,
      CSR_WIDE_WINDOW   = 3'd5,
      CSR_NARROW_WINDOW = 3'd6,
      CSR_RECORD_LENGTH = 3'd7
   } csr_index_type;

   // per-channel running state
   typedef struct packed {
      logic [SUM_W-1:0]    sum;
      logic [SAMPLE_W-1:0] max_val;
      logic [IDX_W-1:0]    max_pos;
      logic [SAMPLE_W-1:0] min_val;
      logic [IDX_W-1:0]    min_pos;
   } chan_acc_type;

   // control shared by all channel trackers
   typedef struct packed {
      logic             accept;
      logic             first;
      logic             in_ped;
      logic [IDX_W-1:0] idx;
   } chan_ctl_type;

   // value scaled by the pedestal sample count
   function automatic logic [SUM_W-1:0] times_ped(input logic [SAMPLE_W-1:0] v);
      times_ped = SUM_W'(SUM_W'(v) * SUM_W'(PED_COUNT));
   endfunction

endpackage

`default_nettype wire

// ----- sv/wpc_channel.sv -----
// ----------------------------------------------------------------------------
// wpc_channel
// Per-channel tracker: pedestal sum, running max/min and first positions.
// ----------------------------------------------------------------------------
`default_nettype none

module wpc_channel
   import wpc_pkg::*;
(
   input  wire logic                clock,
   input  wire chan_ctl_type        ctl,
   input  wire logic [SAMPLE_W-1:0] sample,
   output chan_acc_type             acc_in
);

   chan_acc_type acc_ff;

   // next state: load on sample zero, otherwise track extremes and sum
   always_comb begin
      acc_in = acc_ff;
      if (ctl.accept) begin
         if (ctl.first) begin
            acc_in.sum     = '0;
            acc_in.max_val = sample;
            acc_in.max_pos = '0;
            acc_in.min_val = sample;
            acc_in.min_pos = '0;
         end else begin
            if (sample > acc_ff.max_val) begin
               acc_in.max_val = sample;
               acc_in.max_pos = ctl.idx;
            end
            if (sample < acc_ff.min_val) begin
               acc_in.min_val = sample;
               acc_in.min_pos = ctl.idx;
            end
            if (ctl.in_ped) begin
               acc_in.sum = acc_ff.sum + SUM_W'(sample);
            end
         end
      end
   end

   // running state
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

// ----- sv/waveform_peak_coincidence_unit.sv -----
// ----------------------------------------------------------------------------
// waveform_peak_coincidence_unit
// Pedestal-subtracted peak finder over four digitizer channels. One request
// carries one sample per channel and is taken every clock; a record of
// record_length requests (clamped to 20..4096) yields one response. Samples
// 1..19 form the pedestal sum, which sets the pulse polarity; amplitudes come
// out as 19 times the true amplitude. The last sample of a record updates the
// channel trackers and is copied into a snapshot register; from the snapshot,
// amplitudes, peak indexes, time difference and flags are computed into the
// response register once that register is empty or being read.
// The snapshot register holds one finished record: while it is full and the
// response register is stalled, requests are held off.
// ----------------------------------------------------------------------------
`default_nettype none

module waveform_peak_coincidence_unit
   import wpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [SAMPLE_W-1:0]   req_sample_ch1,
   input  wire logic [SAMPLE_W-1:0]   req_sample_ch2,
   input  wire logic [SAMPLE_W-1:0]   req_sample_ch3,
   input  wire logic [SAMPLE_W-1:0]   req_sample_ch4,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [SUM_W-1:0]           rsp_amplitude_ch1,
   output logic [SUM_W-1:0]           rsp_amplitude_ch2,
   output logic [SUM_W-1:0]           rsp_amplitude_ch3,
   output logic [SUM_W-1:0]           rsp_amplitude_ch4,
   output logic [IDX_W-1:0]           rsp_peak_index_ch1,
   output logic [IDX_W-1:0]           rsp_peak_index_ch2,
   output logic [IDX_W-1:0]           rsp_peak_index_ch3,
   output logic [IDX_W-1:0]           rsp_peak_index_ch4,
   output logic signed [DT_W-1:0]     rsp_time_difference,
   output logic                       rsp_coincidence_wide,
   output logic                       rsp_coincidence_narrow,
   output logic [CHANNELS-1:0]        rsp_below_threshold_mask
);

   // configuration registers
   logic [SAMPLE_W-1:0] thr_ff [CHANNELS];
   logic [SAMPLE_W-1:0] polarity_ff;
   logic [SAMPLE_W-1:0] wide_ff;
   logic [SAMPLE_W-1:0] narrow_ff;
   logic [LEN_W-1:0]    length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THR_RESET;
         polarity_ff <= POLARITY_RESET;
         wide_ff     <= WIDE_RESET;
         narrow_ff   <= NARROW_RESET;
         length_ff   <= LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD_CH1: thr_ff[0]   <= csr_write_data[SAMPLE_W-1:0];
            CSR_THRESHOLD_CH2: thr_ff[1]   <= csr_write_data[SAMPLE_W-1:0];
            CSR_THRESHOLD_CH3: thr_ff[2]   <= csr_write_data[SAMPLE_W-1:0];
            CSR_THRESHOLD_CH4: thr_ff[3]   <= csr_write_data[SAMPLE_W-1:0];
            CSR_POLARITY:      polarity_ff <= csr_write_data[SAMPLE_W-1:0];
            CSR_WIDE_WINDOW:   wide_ff     <= csr_write_data[SAMPLE_W-1:0];
            CSR_NARROW_WINDOW: narrow_ff   <= csr_write_data[SAMPLE_W-1:0];
            CSR_RECORD_LENGTH: length_ff   <= csr_write_data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake and stage control
   logic fin_valid_ff, fin_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_adv;
   logic req_accept;

   assign rsp_adv    = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !fin_valid_ff || rsp_adv;
   assign req_accept = req_valid && req_ready;

   // effective record length and sample counter
   logic [LEN_W-1:0] eff_len;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] cnt_plus;
   logic             last_sample;

   always_comb begin
      if (length_ff < LEN_W'(MIN_RECORD)) begin
         eff_len = LEN_W'(MIN_RECORD);
      end else if (length_ff > LEN_W'(MAX_RECORD)) begin
         eff_len = LEN_W'(MAX_RECORD);
      end else begin
         eff_len = length_ff;
      end
   end

   assign cnt_plus    = {1'b0, cnt_ff} + LEN_W'(1);
   assign last_sample = cnt_plus >= eff_len;

   always_comb begin
      cnt_in = cnt_ff;
      if (req_accept) begin
         cnt_in = last_sample ? '0 : cnt_plus[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // channel trackers
   chan_ctl_type        ctl;
   logic [SAMPLE_W-1:0] samples [CHANNELS];
   chan_acc_type        acc_in [CHANNELS];

   assign ctl.accept = req_accept;
   assign ctl.first  = (cnt_ff == '0);
   assign ctl.in_ped = (cnt_ff <= IDX_W'(PED_COUNT));
   assign ctl.idx    = cnt_ff;

   assign samples[0] = req_sample_ch1;
   assign samples[1] = req_sample_ch2;
   assign samples[2] = req_sample_ch3;
   assign samples[3] = req_sample_ch4;

   for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
      wpc_channel u_chan (
         .clock  (clock),
         .ctl    (ctl),
         .sample (samples[c]),
         .acc_in (acc_in[c])
      );
   end

   // snapshot of a finished record
   chan_acc_type fin_acc_ff [CHANNELS];

   assign fin_valid_in = (req_accept && last_sample) ? 1'b1
                       : (rsp_adv ? 1'b0 : fin_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && last_sample) begin
         fin_acc_ff <= acc_in;
      end
   end

   // amplitude, peak index and threshold test per channel
   logic [SUM_W-1:0]        level_scaled;
   logic [SUM_W-1:0]        amp_in [CHANNELS];
   logic [IDX_W-1:0]        pos_in [CHANNELS];
   logic [CHANNELS-1:0]     mask_in;
   logic [SUM_W-1:0]        top [CHANNELS];
   logic [SUM_W-1:0]        bot [CHANNELS];

   assign level_scaled = times_ped(polarity_ff);

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         top[c] = times_ped(fin_acc_ff[c].max_val);
         bot[c] = times_ped(fin_acc_ff[c].min_val);
         if (fin_acc_ff[c].sum < level_scaled) begin
            amp_in[c] = (top[c] > fin_acc_ff[c].sum) ? top[c] - fin_acc_ff[c].sum : '0;
            pos_in[c] = fin_acc_ff[c].max_pos;
         end else begin
            amp_in[c] = (fin_acc_ff[c].sum > bot[c]) ? fin_acc_ff[c].sum - bot[c] : '0;
            pos_in[c] = fin_acc_ff[c].min_pos;
         end
         mask_in[c] = amp_in[c] < times_ped(thr_ff[c]);
      end
   end

   // peak time difference and coincidence windows
   logic signed [DT_W-1:0] dt_in;
   logic [DT_W-1:0]        adt;
   logic                   wide_in, narrow_in;

   assign dt_in     = $signed({1'b0, pos_in[1]}) - $signed({1'b0, pos_in[0]});
   assign adt       = dt_in[DT_W-1] ? DT_W'(-dt_in) : DT_W'(dt_in);
   assign wide_in   = adt <= DT_W'(wide_ff);
   assign narrow_in = adt <= DT_W'(narrow_ff);

   // response register
   logic [SUM_W-1:0]       rsp_amp_ff [CHANNELS];
   logic [IDX_W-1:0]       rsp_pos_ff [CHANNELS];
   logic signed [DT_W-1:0] rsp_dt_ff;
   logic                   rsp_wide_ff, rsp_narrow_ff;
   logic [CHANNELS-1:0]    rsp_mask_ff;
   logic                   rsp_load;

   assign rsp_load     = fin_valid_ff && rsp_adv;
   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_amp_ff    <= amp_in;
         rsp_pos_ff    <= pos_in;
         rsp_dt_ff     <= dt_in;
         rsp_wide_ff   <= wide_in;
         rsp_narrow_ff <= narrow_in;
         rsp_mask_ff   <= mask_in;
      end
   end

   // output ports
   assign rsp_valid                = rsp_valid_ff;
   assign rsp_amplitude_ch1        = rsp_amp_ff[0];
   assign rsp_amplitude_ch2        = rsp_amp_ff[1];
   assign rsp_amplitude_ch3        = rsp_amp_ff[2];
   assign rsp_amplitude_ch4        = rsp_amp_ff[3];
   assign rsp_peak_index_ch1       = rsp_pos_ff[0];
   assign rsp_peak_index_ch2       = rsp_pos_ff[1];
   assign rsp_peak_index_ch3       = rsp_pos_ff[2];
   assign rsp_peak_index_ch4       = rsp_pos_ff[3];
   assign rsp_time_difference      = rsp_dt_ff;
   assign rsp_coincidence_wide     = rsp_wide_ff;
   assign rsp_coincidence_narrow   = rsp_narrow_ff;
   assign rsp_below_threshold_mask = rsp_mask_ff;

   // a request ending a record always lands in the snapshot stage
   a_last_fills_snapshot: assert property (@(posedge clock) disable iff (reset)
      req_accept && last_sample |=> fin_valid_ff)
      else $error("finished record not captured");

   // a stalled snapshot is never dropped
   a_snapshot_held: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !rsp_adv |=> fin_valid_ff)
      else $error("snapshot lost while response stalled");

   // a new response only follows a full snapshot
   a_rsp_from_snapshot: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(fin_valid_ff))
      else $error("response raised without a finished record");

endmodule

`default_nettype wire

// ----- sim/waveform_peak_coincidence_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_peak_coincidence_unit_tb
// Self-checking bench for the peak coincidence unit. Records of pulse-shaped,
// flat and noise samples go in over the request channel in random bursts and
// gaps. An in-bench peak tracker predicts the response of each record. Responses
// are taken on a stall pattern of their own and checked field by field in order.
// The register settings change between phases; all but the length reach extremes.
// ----------------------------------------------------------------------------

module waveform_peak_coincidence_unit_tb;
   import wpc_pkg::*;

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 10;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_RECORDS   = 12;
   localparam int RANDOM_SAMPLES = 1000;
   localparam int HOLD_PHASE     = 2;
   localparam int LONG_PHASE     = 3;
   localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;

   typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] sample_set_type;

   typedef struct packed {
      logic [CHANNELS-1:0][SUM_W-1:0] amplitude;
      logic [CHANNELS-1:0][IDX_W-1:0] peak_index;
      logic signed [DT_W-1:0]         time_diff;
      logic                           wide;
      logic                           narrow;
      logic [CHANNELS-1:0]            below;
   } peak_report_type;

   typedef enum {WAVE_NOISE, WAVE_POSITIVE, WAVE_NEGATIVE, WAVE_FLAT} wave_kind_type;

   typedef struct {
      wave_kind_type kind;
      int            base;
      int            height;
      int            pos;
      int            width;
      int            noise;
   } wave_type;

   typedef enum {READY_ALWAYS, READY_RANDOM, READY_SPARSE, READY_PERIODIC} ready_mode_type;
   typedef enum {PICK_TYPICAL, PICK_LOW, PICK_HIGH} pick_type;

   // block ports
   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                   req_valid        = 1'b0;
   logic                   req_ready;
   logic [SAMPLE_W-1:0]    req_sample_ch1   = '0;
   logic [SAMPLE_W-1:0]    req_sample_ch2   = '0;
   logic [SAMPLE_W-1:0]    req_sample_ch3   = '0;
   logic [SAMPLE_W-1:0]    req_sample_ch4   = '0;
   logic                   rsp_valid;
   logic                   rsp_ready        = 1'b0;
   logic [SUM_W-1:0]       rsp_amplitude_ch1;
   logic [SUM_W-1:0]       rsp_amplitude_ch2;
   logic [SUM_W-1:0]       rsp_amplitude_ch3;
   logic [SUM_W-1:0]       rsp_amplitude_ch4;
   logic [IDX_W-1:0]       rsp_peak_index_ch1;
   logic [IDX_W-1:0]       rsp_peak_index_ch2;
   logic [IDX_W-1:0]       rsp_peak_index_ch3;
   logic [IDX_W-1:0]       rsp_peak_index_ch4;
   logic signed [DT_W-1:0] rsp_time_difference;
   logic                   rsp_coincidence_wide;
   logic                   rsp_coincidence_narrow;
   logic [CHANNELS-1:0]    rsp_below_threshold_mask;

   // register copies seen by the tracker
   logic [SAMPLE_W-1:0] cfg_threshold [CHANNELS];
   logic [SAMPLE_W-1:0] cfg_polarity;
   logic [SAMPLE_W-1:0] cfg_wide;
   logic [SAMPLE_W-1:0] cfg_narrow;
   logic [LEN_W-1:0]    cfg_length;

   // per-channel peak tracker state
   logic [IDX_W-1:0]    trk_count = '0;
   logic [SUM_W-1:0]    trk_sum     [CHANNELS];
   logic [SAMPLE_W-1:0] trk_max     [CHANNELS];
   logic [IDX_W-1:0]    trk_max_pos [CHANNELS];
   logic [SAMPLE_W-1:0] trk_min     [CHANNELS];
   logic [IDX_W-1:0]    trk_min_pos [CHANNELS];

   sample_set_type  pending_samples [$];
   peak_report_type expected_reports [$];
   wave_type        waves [CHANNELS];

   int             samples_queued   = 0;
   int             samples_accepted = 0;
   int             reports_seen     = 0;
   int             mismatch_count   = 0;
   int             cycle_count      = 0;
   int             gen_pos          = 0;
   bit             req_taken        = 1'b0;
   int             burst_left       = 1;
   int             gap_left         = 0;
   bit             sender_gaps      = 1'b1;
   ready_mode_type ready_mode       = READY_ALWAYS;
   int             hold_token       = 0;
   int             hold_seen        = 0;
   int             hold_left        = 0;
   int             stall_tick       = 0;

   waveform_peak_coincidence_unit dut (
      .clock                    (clock),
      .reset                    (reset),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_sample_ch1           (req_sample_ch1),
      .req_sample_ch2           (req_sample_ch2),
      .req_sample_ch3           (req_sample_ch3),
      .req_sample_ch4           (req_sample_ch4),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_amplitude_ch1        (rsp_amplitude_ch1),
      .rsp_amplitude_ch2        (rsp_amplitude_ch2),
      .rsp_amplitude_ch3        (rsp_amplitude_ch3),
      .rsp_amplitude_ch4        (rsp_amplitude_ch4),
      .rsp_peak_index_ch1       (rsp_peak_index_ch1),
      .rsp_peak_index_ch2       (rsp_peak_index_ch2),
      .rsp_peak_index_ch3       (rsp_peak_index_ch3),
      .rsp_peak_index_ch4       (rsp_peak_index_ch4),
      .rsp_time_difference      (rsp_time_difference),
      .rsp_coincidence_wide     (rsp_coincidence_wide),
      .rsp_coincidence_narrow   (rsp_coincidence_narrow),
      .rsp_below_threshold_mask (rsp_below_threshold_mask)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // one sample set through the tracker; a record end queues its peak report
   task automatic track_sample(input sample_set_type smp);
      int unsigned     idx, len, sum, amp;
      int              pos [CHANNELS];
      int              dt, adt, c;
      peak_report_type rep;
      idx = trk_count;
      for (c = 0; c < CHANNELS; c++) begin
         if (idx == 0) begin
            trk_sum[c]     = '0;
            trk_max[c]     = smp[c];
            trk_min[c]     = smp[c];
            trk_max_pos[c] = '0;
            trk_min_pos[c] = '0;
         end else begin
            if (smp[c] > trk_max[c]) begin
               trk_max[c]     = smp[c];
               trk_max_pos[c] = IDX_W'(idx);
            end
            if (smp[c] < trk_min[c]) begin
               trk_min[c]     = smp[c];
               trk_min_pos[c] = IDX_W'(idx);
            end
            if (idx <= PED_COUNT) trk_sum[c] = trk_sum[c] + SUM_W'(smp[c]);
         end
      end
      // record length saturates to the legal span
      len = cfg_length;
      if (len < MIN_RECORD) len = MIN_RECORD;
      if (len > MAX_RECORD) len = MAX_RECORD;
      if (idx + 1 < len) begin
         trk_count = IDX_W'(idx + 1);
      end else begin
         trk_count = '0;
         rep.below = '0;
         for (c = 0; c < CHANNELS; c++) begin
            sum = trk_sum[c];
            // pedestal under the level means a positive pulse
            if (sum < PED_COUNT * cfg_polarity) begin
               amp    = PED_COUNT * trk_max[c];
               amp    = (amp > sum) ? amp - sum : 0;
               pos[c] = trk_max_pos[c];
            end else begin
               amp    = PED_COUNT * trk_min[c];
               amp    = (sum > amp) ? sum - amp : 0;
               pos[c] = trk_min_pos[c];
            end
            if (amp < PED_COUNT * cfg_threshold[c]) rep.below[c] = 1'b1;
            rep.amplitude[c]  = SUM_W'(amp);
            rep.peak_index[c] = IDX_W'(pos[c]);
         end
         dt            = pos[1] - pos[0];
         adt           = (dt < 0) ? -dt : dt;
         rep.time_diff = DT_W'(dt);
         rep.wide      = (adt <= cfg_wide);
         rep.narrow    = (adt <= cfg_narrow);
         expected_reports = {expected_reports, rep};
      end
   endtask

   // driver: note accepted requests at the rising edge
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         track_sample({req_sample_ch4, req_sample_ch3, req_sample_ch2, req_sample_ch1});
         samples_accepted++;
         req_taken = 1'b1;
      end
   end

   // driver: present requests in bursts with gaps, at the falling edge
   always @(negedge clock) begin
      sample_set_type next_set;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            next_set = pending_samples.pop_front();
            req_valid      <= 1'b1;
            req_sample_ch1 <= next_set[0];
            req_sample_ch2 <= next_set[1];
            req_sample_ch3 <= next_set[2];
            req_sample_ch4 <= next_set[3];
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               if (!sender_gaps) gap_left = 0;
               else if ($urandom_range(0, 7) == 0) gap_left = $urandom_range(10, 40);
               else gap_left = $urandom_range(1, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // receiver stall pattern, with an occasional long hold-off
   always @(negedge clock) begin
      if (hold_seen != hold_token) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      stall_tick++;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (ready_mode)
            READY_ALWAYS: rsp_ready <= 1'b1;
            READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_ready <= ($urandom_range(0, 3) != 0);
            default:      rsp_ready <= ((stall_tick % 7) < 3);
         endcase
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // monitor: each response against the oldest predicted report
   always @(posedge clock) begin
      peak_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         reports_seen++;
         if (expected_reports.size() == 0) begin
            $display("%0t ns: response with no record pending, actual amplitude_ch1 %0d",
                     $time, rsp_amplitude_ch1);
            mismatch_count++;
         end else begin
            want = expected_reports.pop_front();
            check_field("amplitude_ch1", want.amplitude[0], rsp_amplitude_ch1);
            check_field("amplitude_ch2", want.amplitude[1], rsp_amplitude_ch2);
            check_field("amplitude_ch3", want.amplitude[2], rsp_amplitude_ch3);
            check_field("amplitude_ch4", want.amplitude[3], rsp_amplitude_ch4);
            check_field("peak_index_ch1", want.peak_index[0], rsp_peak_index_ch1);
            check_field("peak_index_ch2", want.peak_index[1], rsp_peak_index_ch2);
            check_field("peak_index_ch3", want.peak_index[2], rsp_peak_index_ch3);
            check_field("peak_index_ch4", want.peak_index[3], rsp_peak_index_ch4);
            check_field("time_difference", want.time_diff, rsp_time_difference);
            check_field("coincidence_wide", want.wide, rsp_coincidence_wide);
            check_field("coincidence_narrow", want.narrow, rsp_coincidence_narrow);
            check_field("below_threshold_mask", want.below, rsp_below_threshold_mask);
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t ns: timeout after %0d cycles", $time, CYCLE_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic write_register(input csr_index_type idx, input int value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_W'(value);
      case (idx)
         CSR_THRESHOLD_CH1: cfg_threshold[0] = SAMPLE_W'(value);
         CSR_THRESHOLD_CH2: cfg_threshold[1] = SAMPLE_W'(value);
         CSR_THRESHOLD_CH3: cfg_threshold[2] = SAMPLE_W'(value);
         CSR_THRESHOLD_CH4: cfg_threshold[3] = SAMPLE_W'(value);
         CSR_POLARITY:      cfg_polarity = SAMPLE_W'(value);
         CSR_WIDE_WINDOW:   cfg_wide = SAMPLE_W'(value);
         CSR_NARROW_WINDOW: cfg_narrow = SAMPLE_W'(value);
         CSR_RECORD_LENGTH: cfg_length = LEN_W'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_set(input sample_set_type smp);
      pending_samples = {pending_samples, smp};
      samples_queued++;
   endtask

   // all requests taken, all responses back, then let the pipeline drain
   task automatic wait_drained();
      while (samples_accepted != samples_queued || expected_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic pick_type pick_for(input int slot);
      case (slot % 5)
         1:       pick_for = PICK_LOW;
         3:       pick_for = PICK_HIGH;
         default: pick_for = PICK_TYPICAL;
      endcase
   endfunction

   function automatic int pick_value(input pick_type sel, input int lo, input int hi);
      case (sel)
         PICK_LOW:  pick_value = 0;
         PICK_HIGH: pick_value = SAMPLE_MAX;
         default:   pick_value = $urandom_range(lo, hi);
      endcase
   endfunction

   // new waveform per channel at each record start
   task automatic new_waves(input int len);
      int c, r;
      for (c = 0; c < CHANNELS; c++) begin
         r = $urandom_range(0, 99);
         if (r < 15) waves[c].kind = WAVE_NOISE;
         else if (r < 55) waves[c].kind = WAVE_POSITIVE;
         else if (r < 90) waves[c].kind = WAVE_NEGATIVE;
         else waves[c].kind = WAVE_FLAT;
         waves[c].width  = $urandom_range(1, 6);
         waves[c].noise  = $urandom_range(0, 3);
         waves[c].height = $urandom_range(20, 4600);
         waves[c].pos    = $urandom_range(0, len - 1);
         case (waves[c].kind)
            WAVE_POSITIVE: waves[c].base = $urandom_range(0, 1800);
            WAVE_NEGATIVE: waves[c].base = $urandom_range(2200, SAMPLE_MAX);
            default:       waves[c].base = $urandom_range(0, SAMPLE_MAX);
         endcase
      end
      // channel 2 mostly lands near channel 1 so the windows see hits
      if ($urandom_range(0, 9) < 6) begin
         waves[1].pos = waves[0].pos + int'($urandom_range(0, 12)) - 6;
         if (waves[1].pos < 0) waves[1].pos = 0;
         if (waves[1].pos > len - 1) waves[1].pos = len - 1;
      end
      // longest record: peaks at both ends of the index range
      if (len == MAX_RECORD) begin
         waves[0].kind  = WAVE_POSITIVE;
         waves[0].pos   = 0;
         waves[0].noise = 0;
         waves[1].kind  = WAVE_POSITIVE;
         waves[1].pos   = len - 1;
         waves[1].noise = 0;
      end
   endtask

   function automatic logic [SAMPLE_W-1:0] wave_sample(input wave_type w, input int i);
      int v, d, shape;
      case (w.kind)
         WAVE_NOISE: v = $urandom_range(0, SAMPLE_MAX);
         WAVE_FLAT:  v = w.base;
         default: begin
            d     = (i > w.pos) ? i - w.pos : w.pos - i;
            shape = (d < w.width) ? w.height * (w.width - d) / w.width : 0;
            v     = (w.kind == WAVE_POSITIVE) ? w.base + shape : w.base - shape;
            if (w.noise > 0) v = v + int'($urandom_range(0, 2 * w.noise)) - w.noise;
         end
      endcase
      if (v < 0) v = 0;
      if (v > SAMPLE_MAX) v = SAMPLE_MAX;
      wave_sample = SAMPLE_W'(v);
   endfunction

   task automatic queue_samples(input int count, input int len);
      sample_set_type smp;
      int k, c;
      for (k = 0; k < count; k++) begin
         if (gen_pos == 0) new_waves(len);
         for (c = 0; c < CHANNELS; c++) smp[c] = wave_sample(waves[c], gen_pos);
         queue_set(smp);
         gen_pos = (gen_pos + 1 >= len) ? 0 : gen_pos + 1;
      end
   endtask

   initial begin : stimulus
      sample_set_type smp;
      pick_type       pick;
      int             phase, i, c, r, len_value, len_eff, n_items, random_samples;
      int             longest;
      for (c = 0; c < CHANNELS; c++) cfg_threshold[c] = THR_RESET[c];
      cfg_polarity   = POLARITY_RESET;
      cfg_wide       = WIDE_RESET;
      cfg_narrow     = NARROW_RESET;
      cfg_length     = LENGTH_RESET;
      random_samples = 0;
      longest        = MIN_RECORD;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed record: length below range, full-scale and zero channels,
      // a positive and a negative pulse with tied extremes
      write_register(CSR_RECORD_LENGTH, 0);
      for (i = 0; i < MIN_RECORD; i++) begin
         smp[0] = SAMPLE_W'(SAMPLE_MAX);
         smp[1] = '0;
         smp[2] = (i == 10 || i == 15) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(100);
         smp[3] = (i == 5 || i == 12) ? SAMPLE_W'(0) : SAMPLE_W'(4000);
         queue_set(smp);
      end
      wait_drained();

      // random phases, each on its own register setting
      phase = 0;
      while (random_samples < RANDOM_SAMPLES || phase <= LONG_PHASE) begin
         pick = pick_for(phase);
         for (c = 0; c < CHANNELS; c++)
            write_register(csr_index_type'(int'(CSR_THRESHOLD_CH1) + c),
                           pick_value(pick, 0, 1500));
         write_register(CSR_POLARITY, pick_value(pick_for(phase + 1), 1200, 2800));
         write_register(CSR_WIDE_WINDOW, pick_value(pick_for(phase + 2), 0, 12));
         write_register(CSR_NARROW_WINDOW, pick_value(pick_for(phase + 4), 0, 4));

         r = $urandom_range(0, 99);
         if (phase == HOLD_PHASE) len_value = MIN_RECORD;
         else if (phase == LONG_PHASE) len_value = $urandom_range(200, 300);
         else if (r < 12) len_value = $urandom_range(0, MIN_RECORD - 1);
         else if (r < 20) len_value = MIN_RECORD;
         else if (r < 88) len_value = $urandom_range(MIN_RECORD + 1, 40);
         else len_value = $urandom_range(41, 300);
         write_register(CSR_RECORD_LENGTH, len_value);
         len_eff = (len_value < MIN_RECORD) ? MIN_RECORD :
                   (len_value > MAX_RECORD) ? MAX_RECORD : len_value;
         if (len_eff > longest) longest = len_eff;

         // some phases stop inside a record so the next length lands mid-record
         n_items = len_eff * $urandom_range(1, 4);
         if ($urandom_range(0, 3) == 0) n_items += $urandom_range(1, len_eff - 1);
         sender_gaps = ($urandom_range(0, 3) != 0);
         ready_mode  = ready_mode_type'($urandom_range(0, 3));
         if (phase == LONG_PHASE) n_items = len_eff;
         if (phase == HOLD_PHASE) begin
            // receiver holds off while the sender streams without gaps
            n_items     = HOLD_RECORDS * len_eff;
            sender_gaps = 1'b0;
            hold_token++;
         end
         queue_samples(n_items, len_eff);
         random_samples += n_items;
         wait_drained();
         phase++;
      end

      $display("covered %0d samples over %0d register settings, records of %0d to %0d samples",
               samples_accepted, phase + 1, MIN_RECORD, longest);
      $display("checked %0d responses, %0d field mismatches", reports_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/wpc_pkg.sv
sv/wpc_channel.sv
sv/waveform_peak_coincidence_unit.sv
sim/waveform_peak_coincidence_unit_tb.sv
